// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and sizes for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Store geometry
  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;

  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

  typedef logic signed [DATA_W-1:0] data_t;

  // Command codes carried in the operation field
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SHOW_FWD   = 3'd4;
  localparam logic [2:0] OP_SHOW_BWD   = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Cell update modes, broadcast along the chain
  localparam logic [2:0] MD_HOLD       = 3'd0;
  localparam logic [2:0] MD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] MD_PUSH_BACK  = 3'd2;
  localparam logic [2:0] MD_POP_FRONT  = 3'd3;
  localparam logic [2:0] MD_ROT_L      = 3'd4;
  localparam logic [2:0] MD_ROT_R      = 3'd5;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic [1:0]         status;
    logic               last;
  } out_beat_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic [2:0]         mode;
    logic [COUNT_W-1:0] count;
  } cell_ctl_t;

endpackage

// ===== rtl/core/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue chain: holds an entry and takes a neighbour's value
// on shifts and rotations, or the pushed value on a push to the back.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                      clk,
  input  deq_pkg::cell_ctl_t        ctl,
  input  logic [deq_pkg::IDX_W-1:0] idx,
  input  deq_pkg::data_t            left_d,
  input  deq_pkg::data_t            right_d,
  input  deq_pkg::data_t            wrap_d,
  input  deq_pkg::data_t            push_d,
  output deq_pkg::data_t            q
);

  deq_pkg::data_t                q_r;
  deq_pkg::data_t                q_nxt;
  logic [deq_pkg::COUNT_W-1:0]   pos;
  logic                          occupied;
  logic                          is_tail;

  // Position relative to the fill level
  assign pos      = deq_pkg::COUNT_W'(idx);
  assign occupied = pos < ctl.count;
  assign is_tail  = pos == (ctl.count - deq_pkg::COUNT_W'(1));

  // Pick the next value for this slot
  always_comb begin
    q_nxt = q_r;
    unique case (ctl.mode)
      deq_pkg::MD_PUSH_FRONT: q_nxt = left_d;
      deq_pkg::MD_PUSH_BACK: begin
        if (pos == ctl.count) q_nxt = push_d;
      end
      deq_pkg::MD_POP_FRONT: q_nxt = right_d;
      deq_pkg::MD_ROT_L: begin
        if (occupied) q_nxt = is_tail ? wrap_d : right_d;
      end
      deq_pkg::MD_ROT_R: begin
        if (occupied) q_nxt = left_d;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ===== rtl/core/deq_chain.sv =====
// ----------------------------------------------------------------------------
// deq_chain
// Row of queue cells, front at slot 0; exposes the front and back entries.
// ----------------------------------------------------------------------------
module deq_chain (
  input  logic               clk,
  input  deq_pkg::cell_ctl_t ctl,
  input  deq_pkg::data_t     push_d,
  output deq_pkg::data_t     head_q,
  output deq_pkg::data_t     tail_q
);

  deq_pkg::data_t              cell_q [deq_pkg::DEPTH];
  deq_pkg::data_t              first_left;
  logic [deq_pkg::IDX_W-1:0]   tail_idx;

  // Back entry sits one below the fill level
  assign tail_idx   = deq_pkg::IDX_W'(ctl.count - deq_pkg::COUNT_W'(1));
  assign tail_q     = cell_q[tail_idx];
  assign head_q     = cell_q[0];

  // Slot 0 takes the pushed value, or the back entry on a right rotation
  assign first_left = (ctl.mode == deq_pkg::MD_ROT_R) ? tail_q : push_d;

  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    deq_pkg::data_t left_d;
    deq_pkg::data_t right_d;

    if (i == 0) begin : g_first
      assign left_d = first_left;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end

    if (i == deq_pkg::DEPTH - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end

    deq_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (deq_pkg::IDX_W'(i)),
      .left_d  (left_d),
      .right_d (right_d),
      .wrap_d  (cell_q[0]),
      .push_d  (push_d),
      .q       (cell_q[i])
    );
  end

endmodule

// ===== rtl/core/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed 32-bit entries held in a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_beat carry one command per beat: push front, push
//   back, pop front, pop back, show forward, show backward. Codes 6 and 7
//   are dropped with no result.
//   out_valid/out_stall/out_beat return results. Push and pop give one beat
//   (status ok, empty or full). A show gives one beat per stored entry with
//   last on the final one, or one empty beat when nothing is stored.
// Throughput and order:
//   Push and pop: one per cycle while in_stall is low; result registered
//   and shown the next cycle. A show holds the input: it sets the show
//   state, then rotates out one entry per cycle while the output is free.
// Reset:
//   rst_n (synchronous, active low) empties the queue and clears out_valid.
// Back-pressure:
//   While out_stall is high with a beat valid, the beat holds and in_stall
//   is raised; a show pauses its walk until the output register frees up.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  deq_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output deq_pkg::out_beat_t out_beat
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SHOW = 1'b1;

  logic                        state_r, state_nxt;
  logic [deq_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [deq_pkg::COUNT_W-1:0] remain_r, remain_nxt;
  logic                        bwd_r, bwd_nxt;
  logic                        out_valid_r, out_valid_nxt;
  deq_pkg::out_beat_t          out_beat_r, beat_nxt;
  logic                        load_out;
  logic                        out_free;
  logic                        accept;
  logic                        full;
  logic                        empty;
  deq_pkg::cell_ctl_t          ctl;
  logic [2:0]                  mode;
  deq_pkg::data_t              head_q;
  deq_pkg::data_t              tail_q;

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign full     = count_r == deq_pkg::DEPTH_CNT;
  assign empty    = count_r == '0;

  // Command decode and show walk
  always_comb begin
    mode       = deq_pkg::MD_HOLD;
    count_nxt  = count_r;
    state_nxt  = state_r;
    remain_nxt = remain_r;
    bwd_nxt    = bwd_r;
    load_out   = 1'b0;
    beat_nxt   = '{element: '0, status: deq_pkg::ST_OK, last: 1'b1};
    priority if (accept) begin
      unique case (in_beat.operation)
        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
          load_out = 1'b1;
          if (full) begin
            beat_nxt.status = deq_pkg::ST_FULL;
          end else begin
            mode      = (in_beat.operation == deq_pkg::OP_PUSH_FRONT) ?
                        deq_pkg::MD_PUSH_FRONT : deq_pkg::MD_PUSH_BACK;
            count_nxt = count_r + deq_pkg::COUNT_W'(1);
          end
        end
        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
          load_out = 1'b1;
          if (empty) begin
            beat_nxt.status = deq_pkg::ST_EMPTY;
          end else begin
            mode      = (in_beat.operation == deq_pkg::OP_POP_FRONT) ?
                        deq_pkg::MD_POP_FRONT : deq_pkg::MD_HOLD;
            count_nxt = count_r - deq_pkg::COUNT_W'(1);
          end
        end
        deq_pkg::OP_SHOW_FWD, deq_pkg::OP_SHOW_BWD: begin
          if (empty) begin
            load_out        = 1'b1;
            beat_nxt.status = deq_pkg::ST_EMPTY;
          end else begin
            state_nxt  = ST_SHOW;
            remain_nxt = count_r;
            bwd_nxt    = in_beat.operation == deq_pkg::OP_SHOW_BWD;
          end
        end
        default: begin
          load_out = 1'b0;
        end
      endcase
    end else if (state_r == ST_SHOW && out_free) begin
      load_out         = 1'b1;
      beat_nxt.element = bwd_r ? tail_q : head_q;
      beat_nxt.last    = remain_r == deq_pkg::COUNT_W'(1);
      mode             = bwd_r ? deq_pkg::MD_ROT_R : deq_pkg::MD_ROT_L;
      remain_nxt       = remain_r - deq_pkg::COUNT_W'(1);
      if (remain_r == deq_pkg::COUNT_W'(1)) state_nxt = ST_IDLE;
    end else begin
      load_out = 1'b0;
    end
  end

  assign ctl.mode  = mode;
  assign ctl.count = count_r;

  deq_chain u_chain (
    .clk    (clk),
    .ctl    (ctl),
    .push_d (in_beat.value),
    .head_q (head_q),
    .tail_q (tail_q)
  );

  // Output register: load a new beat, hold while stalled, drop once taken
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      bwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      bwd_r       <= bwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_beat_r <= beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef SYNTHESIS
  // Fill level never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= deq_pkg::DEPTH_CNT)
    else $error("queue fill level beyond depth");

  // A show walk has entries left and never more than are stored
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHOW |-> (remain_r != '0 && remain_r <= count_r))
    else $error("show walk count out of range");

  // The store is not resized during a show walk
  a_walk_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHOW |=> count_r == $past(count_r))
    else $error("fill level changed during show");

  // A new result beat is only loaded when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result beat overwritten while stalled");
`endif

endmodule
